@@ src/mrr_pkg.sv @@
// ----------------------------------------------------------------------------
// mrr_pkg: shared definitions for the Modbus RTU response receiver
// Sizes, protocol constants, register indexes, sequencer states and the
// control word that goes to the bit-serial CRC unit.
// ----------------------------------------------------------------------------
package mrr_pkg;

  // sizes
  localparam int MAX_REGISTERS = 8;
  localparam int IDX_W         = $clog2(MAX_REGISTERS);
  localparam int COUNT_W       = 4;
  localparam int POS_W         = 5;
  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int BIT_CNT_W     = 3;

  // protocol constants
  localparam logic [WORD_W-1:0] CRC_INIT  = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY  = 16'hA001;
  localparam logic [BYTE_W-1:0] FUNC_READ = 8'h03;

  // reset values of the configuration registers
  localparam logic [BYTE_W-1:0]  SLAVE_ADDRESS_RESET  = 8'd1;
  localparam logic [COUNT_W-1:0] REGISTER_COUNT_RESET = 4'd1;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SLAVE_ADDRESS  = 2'd0,
    REG_REGISTER_COUNT = 2'd1
  } cfg_reg_t;

  // result status codes
  localparam logic STATUS_VALID   = 1'b0;
  localparam logic STATUS_CRC_ERR = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRC,
    ST_EMIT
  } seq_state_t;

  // control word to the crc unit
  typedef struct packed {
    logic              start;
    logic              seed;
    logic [BYTE_W-1:0] data;
  } crc_ctrl_t;

endpackage

@@ src/mrr_if.sv @@
// ----------------------------------------------------------------------------
// mrr_if: channel interfaces of the Modbus RTU response receiver
// Received byte channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface mrr_byte_if;
  logic                       valid;
  logic                       ready;
  logic [mrr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrr_result_if;
  logic                            valid;
  logic                            ready;
  logic                            status;
  logic [mrr_pkg::IDX_W-1:0]       register_index;
  logic [mrr_pkg::WORD_W-1:0]      register_value;
  logic                            last;

  modport source (output valid, output status, output register_index,
                  output register_value, output last, input ready);
  modport sink (input valid, input status, input register_index,
                input register_value, input last, output ready);
endinterface

interface mrr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mrr_pkg::CFG_INDEX_W-1:0] index;
  logic [mrr_pkg::BYTE_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/mrr_crc_unit.sv @@
// ----------------------------------------------------------------------------
// mrr_crc_unit: bit-serial CRC-16 engine
// Folds one byte into the running CRC at one bit per cycle (reflected
// polynomial); the seed option restarts from all ones.
// ----------------------------------------------------------------------------
module mrr_crc_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  mrr_pkg::crc_ctrl_t          ctrl,
  output logic                        busy,
  output logic [mrr_pkg::WORD_W-1:0]  crc
);

  logic [mrr_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic [mrr_pkg::WORD_W-1:0]    crc_base;
  logic [mrr_pkg::WORD_W-1:0]    crc_shift;

  // start value and one shift step
  always_comb begin
    crc_base  = ctrl.seed ? mrr_pkg::CRC_INIT : crc;
    crc_shift = crc[0] ? ((crc >> 1) ^ mrr_pkg::CRC_POLY) : (crc >> 1);
  end

  // bit counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (ctrl.start) begin
      busy    <= 1'b1;
      bit_cnt <= '0;
    end else if (busy) begin
      bit_cnt <= bit_cnt + 1'b1;
      if (bit_cnt == {mrr_pkg::BIT_CNT_W{1'b1}}) begin
        busy <= 1'b0;
      end
    end
  end

  // crc register
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      crc <= crc_base ^ {{(mrr_pkg::WORD_W-mrr_pkg::BYTE_W){1'b0}}, ctrl.data};
    end else if (busy) begin
      crc <= crc_shift;
    end
  end

endmodule

@@ src/modbus_rtu_response_receiver_top.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_response_receiver_top: Modbus RTU read-registers response receiver
// Hunts for the slave address, checks function code and byte count, stores
// the data words, checks the trailing CRC-16 and sends out the words or an
// error word.
//
//   channel  role    handshake      payload
//   rx       sink    valid/ready    rx_byte
//   result   source  valid/ready    status, register_index, register_value, last
//   cfg      sink    valid/ready    index, data (always ready)
//
// An address, function or count byte that passes its check, and every data
// byte, is accepted, passes through the shift steps of the bit-serial CRC
// unit and returns to idle, during which rx is not ready.
// A dropped byte and each of the two CRC bytes skip the CRC unit; after the last
// one the block sends the clamped register count of words (or one error word),
// one per cycle while result.ready is high, and takes no byte until the last
// is taken.
// Reset (rst, synchronous) returns to address hunting with slave_address 1
// and register_count 1; the word store is not cleared.
// ----------------------------------------------------------------------------
module modbus_rtu_response_receiver_top (
  input  logic              clk,
  input  logic              rst,
  mrr_byte_if.sink          rx,
  mrr_result_if.source      result,
  mrr_cfg_if.sink           cfg
);

  // configuration registers
  logic [mrr_pkg::BYTE_W-1:0]  slave_address;
  logic [mrr_pkg::COUNT_W-1:0] register_count;

  // frame tracking
  mrr_pkg::seq_state_t          state;
  mrr_pkg::seq_state_t          state_next;
  logic [mrr_pkg::POS_W-1:0]    byte_position;
  logic [mrr_pkg::POS_W-1:0]    byte_position_next;
  logic [mrr_pkg::BYTE_W-1:0]   crc_low_received;
  logic                         err_flag;
  logic [mrr_pkg::IDX_W-1:0]    emit_idx;
  logic [mrr_pkg::IDX_W-1:0]    last_idx;

  // word store, split in bytes
  logic [mrr_pkg::BYTE_W-1:0]   store_hi [mrr_pkg::MAX_REGISTERS];
  logic [mrr_pkg::BYTE_W-1:0]   store_lo [mrr_pkg::MAX_REGISTERS];

  // decode
  logic [mrr_pkg::COUNT_W-1:0]  words;
  logic [mrr_pkg::POS_W-1:0]    dlen;
  logic [mrr_pkg::POS_W-1:0]    data_off;
  logic                         do_feed;
  logic                         do_store;
  logic                         do_low;
  logic                         do_finish;
  logic                         crc_match;
  logic                         rx_fire;
  logic                         res_fire;
  logic                         res_last;

  // crc unit link
  mrr_pkg::crc_ctrl_t           crc_ctrl;
  logic                         crc_busy;
  logic [mrr_pkg::WORD_W-1:0]   crc_value;

  mrr_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .busy (crc_busy),
    .crc  (crc_value)
  );

  assign rx_fire  = rx.valid && rx.ready;
  assign res_fire = result.valid && result.ready;
  assign cfg.ready = 1'b1;

  // clamp the word count to 1..MAX_REGISTERS
  always_comb begin
    if (register_count == '0) begin
      words = mrr_pkg::COUNT_W'(1);
    end else if (register_count > mrr_pkg::COUNT_W'(mrr_pkg::MAX_REGISTERS)) begin
      words = mrr_pkg::COUNT_W'(mrr_pkg::MAX_REGISTERS);
    end else begin
      words = register_count;
    end
    dlen     = mrr_pkg::POS_W'({words, 1'b0});
    data_off = byte_position - mrr_pkg::POS_W'(3);
  end

  // byte decode by frame position
  always_comb begin
    do_feed            = 1'b0;
    do_store           = 1'b0;
    do_low             = 1'b0;
    do_finish          = 1'b0;
    byte_position_next = byte_position;
    if (byte_position > dlen + mrr_pkg::POS_W'(4)) begin
      byte_position_next = '0;
    end else if (byte_position == '0) begin
      if (rx.rx_byte == slave_address) begin
        do_feed            = 1'b1;
        byte_position_next = mrr_pkg::POS_W'(1);
      end
    end else if (byte_position == mrr_pkg::POS_W'(1)) begin
      if (rx.rx_byte == mrr_pkg::FUNC_READ) begin
        do_feed            = 1'b1;
        byte_position_next = mrr_pkg::POS_W'(2);
      end else begin
        byte_position_next = '0;
      end
    end else if (byte_position == mrr_pkg::POS_W'(2)) begin
      if (rx.rx_byte == mrr_pkg::BYTE_W'(dlen)) begin
        do_feed            = 1'b1;
        byte_position_next = mrr_pkg::POS_W'(3);
      end else begin
        byte_position_next = '0;
      end
    end else if (byte_position < dlen + mrr_pkg::POS_W'(3)) begin
      do_store           = 1'b1;
      do_feed            = 1'b1;
      byte_position_next = byte_position + 1'b1;
    end else if (byte_position == dlen + mrr_pkg::POS_W'(3)) begin
      do_low             = 1'b1;
      byte_position_next = byte_position + 1'b1;
    end else begin
      do_finish          = 1'b1;
      byte_position_next = '0;
    end
  end

  assign crc_match = ({rx.rx_byte, crc_low_received} == crc_value);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mrr_pkg::ST_IDLE: begin
        if (rx_fire && do_feed) begin
          state_next = mrr_pkg::ST_CRC;
        end else if (rx_fire && do_finish) begin
          state_next = mrr_pkg::ST_EMIT;
        end
      end
      mrr_pkg::ST_CRC: begin
        if (!crc_busy) begin
          state_next = mrr_pkg::ST_IDLE;
        end
      end
      mrr_pkg::ST_EMIT: begin
        if (res_fire && res_last) begin
          state_next = mrr_pkg::ST_IDLE;
        end
      end
      default: state_next = mrr_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    rx.ready      = 1'b0;
    result.valid  = 1'b0;
    crc_ctrl      = '0;
    crc_ctrl.seed = (byte_position == '0);
    crc_ctrl.data = rx.rx_byte;
    case (state)
      mrr_pkg::ST_IDLE: begin
        rx.ready       = 1'b1;
        crc_ctrl.start = rx.valid && do_feed;
      end
      mrr_pkg::ST_EMIT: begin
        result.valid = 1'b1;
      end
      default: begin
        rx.ready = 1'b0;
      end
    endcase
  end

  // result word
  always_comb begin
    res_last = err_flag || (emit_idx == last_idx);
    result.last = res_last;
    if (err_flag) begin
      result.status         = mrr_pkg::STATUS_CRC_ERR;
      result.register_index = '0;
      result.register_value = '0;
    end else begin
      result.status         = mrr_pkg::STATUS_VALID;
      result.register_index = emit_idx;
      result.register_value = {store_hi[emit_idx], store_lo[emit_idx]};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= mrr_pkg::ST_IDLE;
      byte_position    <= '0;
      crc_low_received <= '0;
      slave_address    <= mrr_pkg::SLAVE_ADDRESS_RESET;
      register_count   <= mrr_pkg::REGISTER_COUNT_RESET;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          mrr_pkg::REG_SLAVE_ADDRESS:  slave_address  <= cfg.data;
          mrr_pkg::REG_REGISTER_COUNT: register_count <= cfg.data[mrr_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      if (rx_fire) begin
        byte_position <= byte_position_next;
        if (do_low) begin
          crc_low_received <= rx.rx_byte;
        end
      end
    end
  end

  // result index and frame verdict
  always_ff @(posedge clk) begin
    if (rx_fire && do_finish) begin
      err_flag <= !crc_match;
      emit_idx <= '0;
      last_idx <= mrr_pkg::IDX_W'(words - 1'b1);
    end else if (res_fire && !res_last) begin
      emit_idx <= emit_idx + 1'b1;
    end
  end

  // data byte store, high byte first
  always_ff @(posedge clk) begin
    if (rx_fire && do_store) begin
      if (!data_off[0]) begin
        store_hi[data_off[mrr_pkg::IDX_W:1]] <= rx.rx_byte;
      end else begin
        store_lo[data_off[mrr_pkg::IDX_W:1]] <= rx.rx_byte;
      end
    end
  end

  // checks
  a_no_rx_while_sending: assert property (@(posedge clk) disable iff (rst)
    !(rx.ready && result.valid))
    else $error("byte accepted while results pending");

  a_crc_only_in_crc_state: assert property (@(posedge clk) disable iff (rst)
    crc_busy |-> (state == mrr_pkg::ST_CRC))
    else $error("crc unit busy outside crc state");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && result.last) |=> !result.valid)
    else $error("result after last word of frame");

  a_error_word_shape: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status) |-> (result.last && result.register_index == '0))
    else $error("malformed crc error word");

endmodule
